@@ rtl/core/rm_pkg.sv @@
package rm_pkg;

	localparam int unsigned MAX_SAMPLES = 1024;
	localparam int unsigned DATA_W      = 32;
	// one heap holds at most half the samples plus one during a rebalance
	localparam int unsigned HEAP_DEPTH  = MAX_SAMPLES / 2 + 2;
	localparam int unsigned IDX_W       = $clog2(HEAP_DEPTH);
	localparam int unsigned TOT_W       = $clog2(MAX_SAMPLES + 1);
	localparam int unsigned ADDR_W      = IDX_W + 1;

	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic [IDX_W-1:0]         idx_t;
	typedef logic [TOT_W-1:0]         tot_t;

	// heap select: lower half is a max-heap, upper half a min-heap
	localparam logic SEL_LOWER = 1'b0;
	localparam logic SEL_UPPER = 1'b1;

	// true when a belongs above b in the heap picked by sel
	function automatic logic above(data_t a, data_t b, logic sel);
		logic r;
		if (sel == SEL_LOWER) begin
			r = a > b;
		end else begin
			r = a < b;
		end
		return r;
	endfunction

endpackage

@@ rtl/core/rm_in_if.sv @@
interface rm_in_if;
	logic                 valid;
	logic                 ready;
	rm_pkg::data_t        sample;
	logic                 restart;

	modport source  (output valid, output sample, output restart, input ready);
	modport sink    (input valid, input sample, input restart, output ready);
	modport monitor (input valid, input sample, input restart, input ready);
endinterface

@@ rtl/core/rm_out_if.sv @@
interface rm_out_if;
	logic                 valid;
	logic                 ready;
	rm_pkg::data_t        median;
	logic                 dropped;

	modport source  (output valid, output median, output dropped, input ready);
	modport sink    (input valid, input median, input dropped, output ready);
	modport monitor (input valid, input median, input dropped, input ready);
endinterface

@@ rtl/core/running_median.sv @@
// Running median over all samples since the last restart, kept as a max-heap
// of the lower half and a min-heap of the upper half in one heap memory with
// a single registered read port. A dropped sample goes straight to the
// result; otherwise every level of a sift-up costs a read and a write, every
// level of a sift-down two child reads and a decision, and an insert that
// needs a rebalance runs a push, a pop and a second push.
// A new item is taken once the previous one has left the sequencer, even
// while its result still waits in the output register. When both heaps
// together hold MAX_SAMPLES entries a sample is dropped, flagged, and the
// current median is repeated.
module running_median (
	input  logic      clk,
	input  logic      arst_n,
	rm_in_if.sink     in_ch,
	rm_out_if.source  out_ch
);

	typedef enum logic [3:0] {
		S_IDLE, S_UP, S_UP_CMP, S_AFTER, S_POP_LAST, S_POP_LD,
		S_DN, S_DN_L, S_DN_R, S_DN_DEC, S_PUSH2, S_FIN
	} state_t;

	state_t          state_q;
	logic            sel_q;
	rm_pkg::idx_t    idx_q;
	rm_pkg::idx_t    n_q;
	rm_pkg::idx_t    best_q;
	rm_pkg::data_t   val_q;
	rm_pkg::data_t   bval_q;
	rm_pkg::data_t   popv_q;
	logic            bchild_q;
	logic            rebal_q;
	logic            drop_q;
	rm_pkg::idx_t    lcnt_q;
	rm_pkg::idx_t    ucnt_q;
	rm_pkg::data_t   ltop_q;
	rm_pkg::data_t   utop_q;
	logic            ov_q;
	rm_pkg::data_t   med_q;
	logic            odrop_q;

	// heap memory: {heap select, index}
	rm_pkg::data_t   mem [2**rm_pkg::ADDR_W];
	rm_pkg::data_t   rd_q;
	logic                      rd_en, wr_en;
	logic [rm_pkg::IDX_W-1:0]  rd_idx, wr_idx;
	rm_pkg::data_t             wr_data;

	// index helpers
	logic [rm_pkg::IDX_W:0] lchild, rchild, nwide;
	rm_pkg::idx_t           parent;
	rm_pkg::idx_t           cnt_sel, cnt_oth;
	logic                   up_more;

	// entry accept decode
	rm_pkg::idx_t    lc_in, uc_in;
	rm_pkg::tot_t    tot_in;
	logic            to_lower;

	// median of the stored set
	rm_pkg::tot_t           total;
	logic signed [rm_pkg::DATA_W:0] sum;
	logic signed [rm_pkg::DATA_W:0] half;
	rm_pkg::data_t          med_now;

	assign in_ch.ready    = (state_q == S_IDLE);
	assign out_ch.valid   = ov_q;
	assign out_ch.median  = med_q;
	assign out_ch.dropped = odrop_q;

	assign lchild  = {idx_q, 1'b1};
	assign rchild  = lchild + 1'b1;
	assign nwide   = {1'b0, n_q};
	assign parent  = (idx_q - 1'b1) >> 1;
	assign cnt_sel = (sel_q == rm_pkg::SEL_LOWER) ? lcnt_q : ucnt_q;
	assign cnt_oth = (sel_q == rm_pkg::SEL_LOWER) ? ucnt_q : lcnt_q;
	assign up_more = {1'b0, cnt_sel} > ({1'b0, cnt_oth} + 1'b1);

	assign lc_in    = in_ch.restart ? '0 : lcnt_q;
	assign uc_in    = in_ch.restart ? '0 : ucnt_q;
	assign tot_in   = rm_pkg::tot_t'(lc_in) + rm_pkg::tot_t'(uc_in);
	assign to_lower = (lc_in != '0) && (ltop_q > in_ch.sample);

	// form the median from the counts and the two tops
	always_comb begin
		total   = rm_pkg::tot_t'(lcnt_q) + rm_pkg::tot_t'(ucnt_q);
		sum     = {ltop_q[rm_pkg::DATA_W-1], ltop_q} + {utop_q[rm_pkg::DATA_W-1], utop_q};
		half    = (sum + {{rm_pkg::DATA_W{1'b0}}, sum[rm_pkg::DATA_W]}) >>> 1;
		if (total == '0) begin
			med_now = '0;
		end else if (total[0]) begin
			med_now = (lcnt_q > ucnt_q) ? ltop_q : utop_q;
		end else begin
			med_now = half[rm_pkg::DATA_W-1:0];
		end
	end

	// drive the memory port from the sequencer state
	always_comb begin
		rd_en   = 1'b0;
		rd_idx  = '0;
		wr_en   = 1'b0;
		wr_idx  = idx_q;
		wr_data = val_q;
		unique case (state_q)
			S_UP: begin
				if (idx_q == '0) begin
					wr_en = 1'b1;
				end else begin
					rd_en  = 1'b1;
					rd_idx = parent;
				end
			end
			S_UP_CMP: begin
				wr_en = 1'b1;
				if (rm_pkg::above(val_q, rd_q, sel_q)) begin
					wr_data = rd_q;
				end
			end
			S_POP_LAST: begin
				rd_en  = 1'b1;
				rd_idx = n_q;
			end
			S_DN: begin
				if (lchild < nwide) begin
					rd_en  = 1'b1;
					rd_idx = lchild[rm_pkg::IDX_W-1:0];
				end else begin
					wr_en = 1'b1;
				end
			end
			S_DN_L: begin
				if (rchild < nwide) begin
					rd_en  = 1'b1;
					rd_idx = rchild[rm_pkg::IDX_W-1:0];
				end
			end
			S_DN_DEC: begin
				wr_en = 1'b1;
				if (bchild_q) begin
					wr_data = bval_q;
				end
			end
			default: begin
			end
		endcase
	end

	// heap memory with registered read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem[{sel_q, rd_idx}];
		end
		if (wr_en) begin
			mem[{sel_q, wr_idx}] <= wr_data;
		end
	end

	// sequencer: insert, rebalance, hand the result over
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			lcnt_q  <= '0;
			ucnt_q  <= '0;
			ov_q    <= 1'b0;
			rebal_q <= 1'b0;
			drop_q  <= 1'b0;
		end else begin
			// drop a taken result unless the next one loads this cycle
			if (out_ch.ready && state_q != S_FIN) begin
				ov_q <= 1'b0;
			end
			// mirror heap roots
			if (wr_en && wr_idx == '0) begin
				if (sel_q == rm_pkg::SEL_LOWER) begin
					ltop_q <= wr_data;
				end else begin
					utop_q <= wr_data;
				end
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_ch.valid) begin
						val_q   <= in_ch.sample;
						rebal_q <= 1'b1;
						if (tot_in >= rm_pkg::tot_t'(rm_pkg::MAX_SAMPLES)) begin
							drop_q  <= 1'b1;
							lcnt_q  <= lc_in;
							ucnt_q  <= uc_in;
							state_q <= S_FIN;
						end else if (to_lower) begin
							drop_q  <= 1'b0;
							sel_q   <= rm_pkg::SEL_LOWER;
							idx_q   <= lc_in;
							lcnt_q  <= lc_in + 1'b1;
							ucnt_q  <= uc_in;
							state_q <= S_UP;
						end else begin
							drop_q  <= 1'b0;
							sel_q   <= rm_pkg::SEL_UPPER;
							idx_q   <= uc_in;
							ucnt_q  <= uc_in + 1'b1;
							lcnt_q  <= lc_in;
							state_q <= S_UP;
						end
					end
				end
				S_UP: begin
					state_q <= (idx_q == '0) ? S_AFTER : S_UP_CMP;
				end
				S_UP_CMP: begin
					if (rm_pkg::above(val_q, rd_q, sel_q)) begin
						idx_q   <= parent;
						state_q <= S_UP;
					end else begin
						state_q <= S_AFTER;
					end
				end
				S_AFTER: begin
					rebal_q <= 1'b0;
					if (rebal_q && up_more) begin
						n_q    <= cnt_sel - 1'b1;
						popv_q <= (sel_q == rm_pkg::SEL_LOWER) ? ltop_q : utop_q;
						if (sel_q == rm_pkg::SEL_LOWER) begin
							lcnt_q <= lcnt_q - 1'b1;
						end else begin
							ucnt_q <= ucnt_q - 1'b1;
						end
						state_q <= S_POP_LAST;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_POP_LAST: begin
					state_q <= S_POP_LD;
				end
				S_POP_LD: begin
					val_q   <= rd_q;
					idx_q   <= '0;
					state_q <= S_DN;
				end
				S_DN: begin
					state_q <= (lchild < nwide) ? S_DN_L : S_PUSH2;
				end
				S_DN_L: begin
					best_q   <= lchild[rm_pkg::IDX_W-1:0];
					bchild_q <= rm_pkg::above(rd_q, val_q, sel_q);
					bval_q   <= rm_pkg::above(rd_q, val_q, sel_q) ? rd_q : val_q;
					state_q  <= (rchild < nwide) ? S_DN_R : S_DN_DEC;
				end
				S_DN_R: begin
					if (rm_pkg::above(rd_q, bval_q, sel_q)) begin
						bval_q   <= rd_q;
						best_q   <= rchild[rm_pkg::IDX_W-1:0];
						bchild_q <= 1'b1;
					end
					state_q <= S_DN_DEC;
				end
				S_DN_DEC: begin
					if (bchild_q) begin
						idx_q   <= best_q;
						state_q <= S_DN;
					end else begin
						state_q <= S_PUSH2;
					end
				end
				S_PUSH2: begin
					sel_q <= ~sel_q;
					idx_q <= cnt_oth;
					val_q <= popv_q;
					if (sel_q == rm_pkg::SEL_LOWER) begin
						ucnt_q <= ucnt_q + 1'b1;
					end else begin
						lcnt_q <= lcnt_q + 1'b1;
					end
					state_q <= S_UP;
				end
				S_FIN: begin
					if (!ov_q || out_ch.ready) begin
						ov_q    <= 1'b1;
						med_q   <= med_now;
						odrop_q <= drop_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// heaps stay balanced between items
	a_balanced: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> ({1'b0, lcnt_q} <= {1'b0, ucnt_q} + 1'b1)
			&& ({1'b0, ucnt_q} <= {1'b0, lcnt_q} + 1'b1))
		else $error("heap sizes out of balance");

	// stored total never exceeds capacity
	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		total <= rm_pkg::tot_t'(rm_pkg::MAX_SAMPLES))
		else $error("stored total above capacity");

	// a full set without restart goes straight to the result
	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready && !in_ch.restart
			&& total >= rm_pkg::tot_t'(rm_pkg::MAX_SAMPLES)
		|=> state_q == S_FIN && drop_q)
		else $error("full set did not drop the item");

	// memory is written only by the sift states
	a_wr_states: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> state_q == S_UP || state_q == S_UP_CMP
			|| state_q == S_DN || state_q == S_DN_DEC)
		else $error("heap write outside a sift");

endmodule
